@@ rtl/isg_pkg.sv @@
// Package for the inverse-square gravity accumulator.
// Opcodes, sequencer states and arithmetic widths. No dependencies.
package isg_pkg;

  localparam int unsigned DW   = 33;   // delta magnitude width
  localparam int unsigned QW   = 68;   // sum of squares width
  localparam int unsigned RW   = 34;   // root width
  localparam int unsigned DENW = 102;  // Q*R width
  localparam int unsigned NUMW = 104;  // 100*S*|D|<<32 width
  localparam int unsigned ACCW = 50;   // signed accumulator width, 256 capped terms
  localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DELTA,
    ST_SQ,
    ST_SQRT,
    ST_DEN,
    ST_NUM,
    ST_DIV,
    ST_ACC,
    ST_CLIP,
    ST_OUT
  } state_t;

endpackage

@@ rtl/inverse_square_gravity_sum_core.sv @@
// Inverse-square gravity accumulator over a table of planet positions.
// Uses isg_pkg. Bit-serial sequencer: squares, root, products and the
// divide each run one bit per cycle through shift registers.
//
// Input channel in_*: opcode 0 clears the table, 1 appends a planet
// (ignored when full), 2 queries the body at pos_* with strength, 3 is
// ignored. Only a query makes a beat on out_*.
// Clear, append and opcode 3 finish in IDLE. A query steps each stored
// planet through the serial multiplier, root and the 104-step restoring
// divider (a planet at zero distance skips the root, products and divide),
// which one shared datapath runs for every planet and axis in turn.
// in_ready is high only in IDLE; the result sits in an output register
// until taken, and the next item is accepted once it is taken.
// Reset (rst_n low, synchronous) empties the table and the result register.
module inverse_square_gravity_sum_core #(
  parameter int unsigned MAX_PLANETS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [31:0] in_strength,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic        out_saturated,
  output logic        out_coincident
);
  import isg_pkg::*;

  localparam int unsigned IW = (MAX_PLANETS > 1) ? $clog2(MAX_PLANETS) : 1;
  localparam int unsigned CW = $clog2(MAX_PLANETS + 1);

  logic [31:0] mem_x [MAX_PLANETS];
  logic [31:0] mem_y [MAX_PLANETS];
  logic [31:0] mem_z [MAX_PLANETS];
  logic [31:0] rd_x_r, rd_y_r, rd_z_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [6:0]  bit_r, bit_nxt;
  logic [1:0]  axis_r, axis_nxt;

  logic signed [31:0] bx_r, by_r, bz_r;
  logic [38:0] s100_r, s100_nxt;
  logic [DW-1:0] dm_r [3];
  logic [DW-1:0] dm_nxt [3];
  logic [2:0]    dneg_r, dneg_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [RW-1:0] root_r, root_nxt;
  logic [QW+1:0] rem_r, rem_nxt;      // root remainder
  logic [DENW-1:0] den_r, den_nxt;
  logic [NUMW-1:0] num_r, num_nxt;    // product, then dividend shift
  logic [DENW:0] drem_r, drem_nxt;    // divider partial remainder
  logic [NUMW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] mpl_r, mpl_nxt;      // serial multiplier shifting operand
  logic signed [ACCW-1:0] acc_r [3];
  logic signed [ACCW-1:0] acc_nxt [3];
  logic sat_r, sat_nxt, coin_r, coin_nxt;
  logic [31:0] fx_r, fy_r, fz_r, fx_nxt, fy_nxt, fz_nxt;
  logic osat_r, ocoin_r, osat_nxt, ocoin_nxt, ovalid_r, ovalid_nxt;

  logic in_fire;
  logic [IW-1:0] rd_idx;
  logic [QW+1:0] trial;
  logic [DENW:0] dsh;
  logic [40:0] mterm;
  logic signed [ACCW-1:0] term;
  logic [31:0] clipv;
  logic clipo;
  logic signed [ACCW-1:0] acc_sel;

  assign in_ready = (state_r == ST_IDLE) && !ovalid_r;
  assign in_fire  = in_valid && in_ready;
  assign rd_idx   = idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && (in_opcode == OP_APPEND) && (count_r < CW'(MAX_PLANETS))) begin
      mem_x[count_r[IW-1:0]] <= in_pos_x;
      mem_y[count_r[IW-1:0]] <= in_pos_y;
      mem_z[count_r[IW-1:0]] <= in_pos_z;
    end
    rd_x_r <= mem_x[rd_idx];
    rd_y_r <= mem_y[rd_idx];
    rd_z_r <= mem_z[rd_idx];
    if (in_fire) begin
      bx_r <= in_pos_x;
      by_r <= in_pos_y;
      bz_r <= in_pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r <= idx_nxt;  bit_r <= bit_nxt;  axis_r <= axis_nxt;
    s100_r <= s100_nxt;  dneg_r <= dneg_nxt;  q_r <= q_nxt;
    root_r <= root_nxt;  rem_r <= rem_nxt;  den_r <= den_nxt;
    num_r <= num_nxt;  drem_r <= drem_nxt;  quo_r <= quo_nxt;
    mpl_r <= mpl_nxt;  sat_r <= sat_nxt;  coin_r <= coin_nxt;
    fx_r <= fx_nxt;  fy_r <= fy_nxt;  fz_r <= fz_nxt;
    osat_r <= osat_nxt;  ocoin_r <= ocoin_nxt;
    for (int k = 0; k < 3; k++) begin
      dm_r[k]  <= dm_nxt[k];
      acc_r[k] <= acc_nxt[k];
    end
  end

  always_comb begin
    acc_sel = acc_r[axis_r == 2'd0 ? 0 : (axis_r == 2'd1 ? 1 : 2)];
    clipv = acc_sel[31:0];
    clipo = 1'b0;
    if (acc_sel > ACCW'(signed'(32'sh7fffffff))) begin
      clipv = 32'h7fffffff; clipo = 1'b1;
    end else if (acc_sel < -ACCW'(33'sh80000000)) begin
      clipv = 32'h80000000; clipo = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;  count_nxt = count_r;  idx_nxt = idx_r;
    bit_nxt = bit_r;  axis_nxt = axis_r;  s100_nxt = s100_r;
    dneg_nxt = dneg_r;  q_nxt = q_r;  root_nxt = root_r;  rem_nxt = rem_r;
    den_nxt = den_r;  num_nxt = num_r;  drem_nxt = drem_r;  quo_nxt = quo_r;
    mpl_nxt = mpl_r;  sat_nxt = sat_r;  coin_nxt = coin_r;
    fx_nxt = fx_r;  fy_nxt = fy_r;  fz_nxt = fz_r;
    osat_nxt = osat_r;  ocoin_nxt = ocoin_r;
    ovalid_nxt = ovalid_r && !out_ready;
    for (int k = 0; k < 3; k++) begin
      dm_nxt[k]  = dm_r[k];
      acc_nxt[k] = acc_r[k];
    end
    trial = '0;  dsh = '0;  mterm = '0;  term = '0;

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_fire) begin
          unique case (op_t'(in_opcode))
            OP_CLEAR:  count_nxt = '0;
            OP_APPEND: if (count_r < CW'(MAX_PLANETS)) count_nxt = count_r + 1'b1;
            OP_QUERY: begin
              s100_nxt = 39'(in_strength) * 39'd100;
              sat_nxt = 1'b0;  coin_nxt = 1'b0;
              for (int k = 0; k < 3; k++) acc_nxt[k] = '0;
              state_nxt = ST_LOAD;
            end
            OP_NONE: ;
          endcase
        end
      end
      ST_LOAD: begin   // table read data registered this cycle
        if (idx_r >= count_r) begin
          axis_nxt = 2'd0;
          state_nxt = ST_CLIP;
        end else state_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        begin : dl
          logic signed [32:0] d [3];
          d[0] = 33'(signed'(rd_x_r)) - 33'(bx_r);
          d[1] = 33'(signed'(rd_y_r)) - 33'(by_r);
          d[2] = 33'(signed'(rd_z_r)) - 33'(bz_r);
          for (int k = 0; k < 3; k++) begin
            dneg_nxt[k] = d[k][32];
            dm_nxt[k] = d[k][32] ? DW'(-d[k]) : DW'(d[k]);
          end
        end
        q_nxt = '0;  axis_nxt = 2'd0;  bit_nxt = '0;
        mpl_nxt = dm_nxt[0];
        state_nxt = ST_SQ;
      end
      ST_SQ: begin   // shift-add square, one multiplier bit per cycle
        if (mpl_r[0])
          q_nxt = q_r + (QW'(dm_r[axis_r]) << bit_r[5:0]);
        mpl_nxt = mpl_r >> 1;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 7'(DW - 1)) begin
          bit_nxt = '0;
          if (axis_r == 2'd2) begin
            if (q_nxt == '0) begin
              coin_nxt = 1'b1;
              idx_nxt = idx_r + 1'b1;
              state_nxt = ST_LOAD;
            end else begin
              root_nxt = '0;  rem_nxt = '0;
              bit_nxt = 7'(RW - 1);
              state_nxt = ST_SQRT;
            end
          end else begin
            axis_nxt = axis_r + 1'b1;
            mpl_nxt = dm_r[axis_r + 1'b1];
          end
        end
      end
      ST_SQRT: begin   // digit-by-digit root, two bits of Q per cycle
        rem_nxt = {rem_r[QW-1:0], q_r[2*bit_r[5:0]+1 -: 2]};
        trial = {root_r, 2'b01};
        root_nxt = root_r << 1;
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          root_nxt[0] = 1'b1;
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          den_nxt = '0;  mpl_nxt = DW'(0);  bit_nxt = '0;
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin   // Q * R, one root bit per cycle
        if (root_r[bit_r[5:0]])
          den_nxt = den_r + (DENW'(q_r) << bit_r[5:0]);
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 7'(RW - 1)) begin
          axis_nxt = 2'd0;  bit_nxt = '0;  num_nxt = '0;
          state_nxt = ST_NUM;
        end
      end
      ST_NUM: begin   // 100*S*|D|, one bit of |D| per cycle
        if (dm_r[axis_r][bit_r[5:0]])
          num_nxt = num_r + (NUMW'(s100_r) << (7'(bit_r[5:0]) + 7'd32));
        bit_nxt = bit_r + 1'b1;
        if (bit_r == 7'(DW - 1)) begin
          bit_nxt = 7'(NUMW - 1);  drem_nxt = '0;  quo_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin   // restoring divide, one quotient bit per cycle
        dsh = {drem_r[DENW-1:0], num_r[NUMW-1]};
        num_nxt = num_r << 1;
        quo_nxt = quo_r << 1;
        drem_nxt = dsh;
        if (dsh >= {1'b0, den_r}) begin
          drem_nxt = dsh - {1'b0, den_r};
          quo_nxt[0] = 1'b1;
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        mterm = quo_r[40:0];
        if ((quo_r[NUMW-1:41] != '0) || (quo_r[40:0] > TERM_CAP)) begin
          mterm = TERM_CAP;  sat_nxt = 1'b1;
        end
        term = ACCW'(mterm);
        acc_nxt[axis_r] = dneg_r[axis_r] ? acc_r[axis_r] - term
                                         : acc_r[axis_r] + term;
        bit_nxt = '0;  num_nxt = '0;
        if (axis_r == 2'd2) begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          axis_nxt = axis_r + 1'b1;
          state_nxt = ST_NUM;
        end
      end
      ST_CLIP: begin
        if (clipo) sat_nxt = 1'b1;
        unique case (axis_r)
          2'd0: fx_nxt = clipv;
          2'd1: fy_nxt = clipv;
          default: fz_nxt = clipv;
        endcase
        axis_nxt = axis_r + 1'b1;
        if (axis_r == 2'd2) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        osat_nxt = sat_r;  ocoin_nxt = coin_r;
        ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid      = ovalid_r;
  assign out_force_x    = fx_r;
  assign out_force_y    = fy_r;
  assign out_force_z    = fz_r;
  assign out_saturated  = osat_r;
  assign out_coincident = ocoin_r;

endmodule

@@ rtl/isg_checker.sv @@
// Port-level checker for inverse_square_gravity_sum_core, bound to the top.
// Depends on the top level's ports only.
module isg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_force_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_force_x))
    else $error("result beat dropped or changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");
endmodule

bind inverse_square_gravity_sum_core isg_checker u_isg_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_force_x(out_force_x)
);
